>>> design/hws_pkg.sv
// Shared types, constants and saturation helpers for the Holt-Winters step unit.
package hws_pkg;

  localparam int SampleW = 16;
  localparam int XW = SampleW + 8;
  localparam int StateW = 32;
  localparam int DevW = 31;
  localparam int GainW = 17;
  localparam int LenW = 7;
  localparam int CfgIdxW = 3;
  localparam int RingW = DevW + StateW;
  localparam int BlendInW = 34;
  localparam int ProdW = BlendInW + 1 + GainW + 1;
  localparam int SumW = ProdW + 1;
  localparam int ResW = SumW - 16;
  localparam int DefaultMaxSeason = 64;

  localparam logic [GainW-1:0] GainOne = 17'd65536;
  localparam logic [GainW-1:0] GainReset = 17'd32768;

  localparam logic [CfgIdxW-1:0] CfgLevelGain = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTrendGain = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSeasonGain = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSeasonLength = 3'd3;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StRead,
    StLevel,
    StDev,
    StWaitLevel,
    StSeason,
    StTrend,
    StWaitSeason,
    StFinish
  } ctrl_state_e;

  typedef enum logic [1:0] {
    OpLevel,
    OpDev,
    OpSeason,
    OpTrend
  } blend_op_e;

  typedef struct packed {
    logic      clr_step;
    logic      load_in;
    logic      rd_next;
    logic      cap_old;
    logic      cap_next;
    logic      issue;
    blend_op_e op;
    logic      cap_lvl;
    logic      cap_dev;
    logic      cap_sea;
    logic      fin;
  } hws_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic clr_last;
    logic out_free;
  } hws_stat_t;

  function automatic logic signed [StateW-1:0] sat32(input logic signed [ResW-1:0] v);
    logic fits;
    fits = (&v[ResW-1:StateW-1]) || !(|v[ResW-1:StateW-1]);
    if (fits) begin
      return v[StateW-1:0];
    end else if (v[ResW-1]) begin
      return {1'b1, {(StateW-1){1'b0}}};
    end else begin
      return {1'b0, {(StateW-1){1'b1}}};
    end
  endfunction

  function automatic logic [DevW-1:0] sat_dev(input logic signed [ResW-1:0] v);
    if (v[ResW-1]) begin
      return '0;
    end else if (|v[ResW-2:DevW]) begin
      return {DevW{1'b1}};
    end else begin
      return v[DevW-1:0];
    end
  endfunction

endpackage

>>> design/holt_winters_smoother_step_unit.sv
// Top level of the Holt-Winters smoother step unit.
// Each accepted sample produces one result: the sample is taken in the idle
// cycle, the ring memory is read for the current and next phase, and four
// gain blends (level, deviation, season, trend) pass through one shared
// two-stage multiplier, with season and trend waiting on the new level. A new
// sample is accepted only after the previous one has been written to the
// output register, where its result may still wait. After reset and after
// every write to one of the four registers, a clearing pass zeroes every entry
// of the seasonal and deviation ring before the first sample is accepted.
// A write to an index beyond the last register is ignored.
module holt_winters_smoother_step_unit #(
  parameter int MAX_SEASON = hws_pkg::DefaultMaxSeason
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // [15:0] sample_in
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [31:0] forecast_next, [63:32] forecast_this, [94:64] deviation_out, [95] zero.
  output logic [95:0]                 m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [hws_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hws_pkg::GainW-1:0]   cfg_data_i
);

  hws_pkg::hws_cmd_t  cmd;
  hws_pkg::hws_stat_t stat;

  logic signed [hws_pkg::StateW-1:0] fnext, fthis;
  logic [hws_pkg::DevW-1:0]          dev;

  hws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hws_dp #(
    .MaxSeason (MAX_SEASON)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .fnext_o     (fnext),
    .fthis_o     (fthis),
    .dev_o       (dev),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign m_axis_tdata = {1'b0, dev, fthis, fnext};

endmodule

>>> design/hws_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hws_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/hws_blend.sv
// Two-stage gain blend unit: g*a + (1-g)*b with g in unsigned Q1.16, round half away from zero.
module hws_blend (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 issue_i,
  input  logic [hws_pkg::GainW-1:0]            gain_i,
  input  logic signed [hws_pkg::BlendInW-1:0]  a_i,
  input  logic signed [hws_pkg::BlendInW-1:0]  b_i,
  output logic signed [hws_pkg::ResW-1:0]      res_o
);

  logic signed [hws_pkg::BlendInW:0]   diff;
  logic signed [hws_pkg::ProdW-1:0]    prod_d;
  logic signed [hws_pkg::ProdW-1:0]    prod_q;
  logic signed [hws_pkg::BlendInW-1:0] b_q;
  logic                                v1_q;
  logic signed [hws_pkg::SumW-1:0]     v;
  logic signed [hws_pkg::SumW-1:0]     rnd;
  logic signed [hws_pkg::SumW-1:0]     sum;
  logic signed [hws_pkg::ResW-1:0]     res_d;
  logic signed [hws_pkg::ResW-1:0]     res_q;

  assign diff   = {a_i[hws_pkg::BlendInW-1], a_i} - {b_i[hws_pkg::BlendInW-1], b_i};
  assign prod_d = $signed({1'b0, gain_i}) * diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q <= prod_d;
      b_q    <= b_i;
    end
    if (v1_q) begin
      res_q <= res_d;
    end
  end

  assign v = {prod_q[hws_pkg::ProdW-1], prod_q}
           + {{(hws_pkg::SumW-hws_pkg::BlendInW-16){b_q[hws_pkg::BlendInW-1]}}, b_q, 16'b0};
  assign rnd = v[hws_pkg::SumW-1] ? hws_pkg::SumW'(32767) : hws_pkg::SumW'(32768);
  assign sum = v + rnd;
  assign res_d = sum[hws_pkg::SumW-1:16];
  assign res_o = res_q;

endmodule

>>> design/hws_ctrl.sv
// Controller state machine that runs the ring clearing pass and sequences one sample through the datapath.
module hws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hws_pkg::hws_stat_t  stat_i,
  output hws_pkg::hws_cmd_t   cmd_o
);

  hws_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hws_pkg::StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hws_pkg::StClear:      if (stat_i.clr_last) state_d = hws_pkg::StIdle;
      hws_pkg::StIdle:       if (in_valid_i) state_d = hws_pkg::StRead;
      hws_pkg::StRead:       state_d = hws_pkg::StLevel;
      hws_pkg::StLevel:      state_d = hws_pkg::StDev;
      hws_pkg::StDev:        state_d = hws_pkg::StWaitLevel;
      hws_pkg::StWaitLevel:  state_d = hws_pkg::StSeason;
      hws_pkg::StSeason:     state_d = hws_pkg::StTrend;
      hws_pkg::StTrend:      state_d = hws_pkg::StWaitSeason;
      hws_pkg::StWaitSeason: state_d = hws_pkg::StFinish;
      hws_pkg::StFinish:     if (stat_i.out_free) state_d = hws_pkg::StIdle;
      default:               state_d = hws_pkg::StClear;
    endcase
    if (stat_i.cfg_hit) begin
      state_d = hws_pkg::StClear;
    end
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = hws_pkg::OpLevel;
    in_ready_o = 1'b0;
    case (state_q)
      hws_pkg::StClear: begin
        cmd_o.clr_step = 1'b1;
      end
      hws_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      hws_pkg::StRead: begin
        cmd_o.rd_next = 1'b1;
        cmd_o.cap_old = 1'b1;
      end
      hws_pkg::StLevel: begin
        cmd_o.cap_next = 1'b1;
        cmd_o.issue    = 1'b1;
        cmd_o.op       = hws_pkg::OpLevel;
      end
      hws_pkg::StDev: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = hws_pkg::OpDev;
      end
      hws_pkg::StWaitLevel: begin
        cmd_o.cap_lvl = 1'b1;
      end
      hws_pkg::StSeason: begin
        cmd_o.issue   = 1'b1;
        cmd_o.op      = hws_pkg::OpSeason;
        cmd_o.cap_dev = 1'b1;
      end
      hws_pkg::StTrend: begin
        cmd_o.issue = 1'b1;
        cmd_o.op    = hws_pkg::OpTrend;
      end
      hws_pkg::StWaitSeason: begin
        cmd_o.cap_sea = 1'b1;
      end
      hws_pkg::StFinish: begin
        cmd_o.fin = stat_i.out_free;
      end
      default: begin
        cmd_o.clr_step = 1'b0;
      end
    endcase
  end

endmodule

>>> design/hws_dp.sv
// Datapath: configuration, smoothing state, ring memory, blend unit and output register.
module hws_dp #(
  parameter int MaxSeason = hws_pkg::DefaultMaxSeason,
  localparam int AddrW = (MaxSeason > 1) ? $clog2(MaxSeason) : 1,
  localparam int PlenW = (AddrW + 1 > hws_pkg::LenW) ? AddrW + 1 : hws_pkg::LenW
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hws_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [hws_pkg::GainW-1:0]          cfg_data_i,
  input  logic signed [hws_pkg::SampleW-1:0] sample_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [hws_pkg::StateW-1:0]  fnext_o,
  output logic signed [hws_pkg::StateW-1:0]  fthis_o,
  output logic [hws_pkg::DevW-1:0]           dev_o,
  input  hws_pkg::hws_cmd_t                  cmd_i,
  output hws_pkg::hws_stat_t                 stat_o
);

  localparam int SW = hws_pkg::StateW;
  localparam int BW = hws_pkg::BlendInW;

  logic [hws_pkg::GainW-1:0] lg_q, tg_q, sg_q;
  logic [hws_pkg::LenW-1:0]  slen_q;
  logic                      cfg_hit;

  logic signed [SW-1:0]          level_q, trend_q, lfc_q;
  logic [hws_pkg::DevW-1:0]      sdev_q;
  logic [AddrW-1:0]              head_q, clr_cnt_q;
  logic signed [hws_pkg::XW-1:0] x_q;
  logic signed [SW-1:0]          s_old_q, s_next_q, nlvl_q;
  logic [hws_pkg::DevW-1:0]      dold_q, ndev_q;

  logic                      out_valid_q;
  logic signed [SW-1:0]      fnext_q, fthis_q;
  logic [hws_pkg::DevW-1:0]  dev_q;

  logic [hws_pkg::GainW-1:0] ga, gb, gg;
  logic [PlenW-1:0]          plen, hn_w;
  logic                      seasonal;
  logic [AddrW-1:0]          h, h_next;

  logic                            ram_we;
  logic [AddrW-1:0]                ram_waddr, ram_raddr;
  logic [hws_pkg::RingW-1:0]       ram_wdata, ram_rdata;
  logic signed [SW-1:0]            ring_sea;
  logic [hws_pkg::DevW-1:0]        ring_dev;

  logic [hws_pkg::GainW-1:0]       bl_gain;
  logic signed [BW-1:0]            bl_a, bl_b;
  logic signed [hws_pkg::ResW-1:0] bl_res;
  logic signed [SW-1:0]            res_sat;
  logic [hws_pkg::DevW-1:0]        res_dev;
  logic signed [BW-1:0]            xe, err_raw, err_abs;
  logic signed [BW-1:0]            fc_sum;
  logic signed [SW-1:0]            fc;

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= hws_pkg::CfgSeasonLength);

  assign ga = (lg_q > hws_pkg::GainOne) ? hws_pkg::GainOne : lg_q;
  assign gb = (tg_q > hws_pkg::GainOne) ? hws_pkg::GainOne : tg_q;
  assign gg = (sg_q > hws_pkg::GainOne) ? hws_pkg::GainOne : sg_q;

  assign plen = (PlenW'(slen_q) > PlenW'(MaxSeason)) ? PlenW'(MaxSeason) : PlenW'(slen_q);
  assign seasonal = (plen != '0);
  assign h = (seasonal && (PlenW'(head_q) < plen)) ? head_q : '0;
  assign hn_w = PlenW'(h) + PlenW'(1);
  assign h_next = (hn_w >= plen) ? '0 : hn_w[AddrW-1:0];

  assign ring_sea = ram_rdata[SW-1:0];
  assign ring_dev = ram_rdata[hws_pkg::RingW-1:SW];

  assign res_sat = hws_pkg::sat32(bl_res);
  assign res_dev = hws_pkg::sat_dev(bl_res);

  assign xe      = BW'(x_q);
  assign err_raw = xe - BW'(lfc_q);
  assign err_abs = err_raw[BW-1] ? -err_raw : err_raw;

  always_comb begin
    bl_gain = ga;
    bl_a    = xe;
    bl_b    = BW'(level_q) + BW'(trend_q);
    case (cmd_i.op)
      hws_pkg::OpLevel: begin
        bl_gain = ga;
        bl_a    = xe - BW'(s_old_q);
        bl_b    = BW'(level_q) + BW'(trend_q);
      end
      hws_pkg::OpDev: begin
        bl_gain = gg;
        bl_a    = err_abs;
        bl_b    = $signed({{(BW-hws_pkg::DevW){1'b0}}, dold_q});
      end
      hws_pkg::OpSeason: begin
        bl_gain = gg;
        bl_a    = xe - BW'(nlvl_q);
        bl_b    = BW'(s_old_q);
      end
      hws_pkg::OpTrend: begin
        bl_gain = gb;
        bl_a    = BW'(nlvl_q) - BW'(level_q);
        bl_b    = BW'(trend_q);
      end
      default: begin
        bl_gain = ga;
      end
    endcase
  end

  hws_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (cmd_i.issue),
    .gain_i  (bl_gain),
    .a_i     (bl_a),
    .b_i     (bl_b),
    .res_o   (bl_res)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = h;
    ram_wdata = {ndev_q, res_sat};
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.cap_sea && seasonal) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = cmd_i.rd_next ? h_next : h;

  hws_ram #(
    .Width (hws_pkg::RingW),
    .Depth (MaxSeason)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign fc_sum = BW'(nlvl_q) + BW'(res_sat) + BW'(s_next_q);
  assign fc     = hws_pkg::sat32(hws_pkg::ResW'(fc_sum));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q      <= hws_pkg::GainReset;
      tg_q      <= hws_pkg::GainReset;
      sg_q      <= hws_pkg::GainReset;
      slen_q    <= '0;
      level_q   <= '0;
      trend_q   <= '0;
      lfc_q     <= '0;
      sdev_q    <= '0;
      head_q    <= '0;
      clr_cnt_q <= '0;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        hws_pkg::CfgLevelGain:    lg_q <= cfg_data_i;
        hws_pkg::CfgTrendGain:    tg_q <= cfg_data_i;
        hws_pkg::CfgSeasonGain:   sg_q <= cfg_data_i;
        hws_pkg::CfgSeasonLength: slen_q <= cfg_data_i[hws_pkg::LenW-1:0];
        default:                  slen_q <= slen_q;
      endcase
      level_q   <= '0;
      trend_q   <= '0;
      lfc_q     <= '0;
      sdev_q    <= '0;
      head_q    <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      if (cmd_i.fin) begin
        level_q <= nlvl_q;
        trend_q <= res_sat;
        lfc_q   <= fc;
        sdev_q  <= ndev_q;
        head_q  <= seasonal ? h_next : '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q <= {sample_i, 8'b0};
    end
    if (cmd_i.cap_old) begin
      s_old_q <= seasonal ? ring_sea : '0;
      dold_q  <= seasonal ? ring_dev : sdev_q;
    end
    if (cmd_i.cap_next) begin
      s_next_q <= seasonal ? ring_sea : '0;
    end
    if (cmd_i.cap_lvl) begin
      nlvl_q <= res_sat;
    end
    if (cmd_i.cap_dev) begin
      ndev_q <= res_dev;
    end
    if (cmd_i.cap_sea && seasonal && (h_next == h)) begin
      s_next_q <= res_sat;
    end
    if (cmd_i.fin) begin
      fnext_q <= fc;
      fthis_q <= lfc_q;
      dev_q   <= seasonal ? dold_q : ndev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fnext_o         = fnext_q;
  assign fthis_o         = fthis_q;
  assign dev_o           = dev_q;
  assign stat_o.cfg_hit  = cfg_hit;
  assign stat_o.clr_last = (clr_cnt_q == AddrW'(MaxSeason - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

>>> dv/holt_winters_smoother_step_unit_test.sv
// Self-checking testbench for the Holt-Winters smoother step unit.
module holt_winters_smoother_step_unit_test;
  import hws_pkg::*;

  localparam int MaxSeason = DefaultMaxSeason;
  localparam longint QOne = 65536;
  localparam longint QHalf = 32768;
  localparam longint S32Max = 64'sd2147483647;
  localparam longint S32Min = -64'sd2147483648;
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;
  localparam int StuckLimit = 3000;
  localparam int DrainCycles = 32;
  localparam int HoldCycles = 400;
  localparam int SendIdle[4] = '{0, 62, 0, 16};
  localparam int RecvStall[4] = '{0, 0, 62, 16};
  localparam int SeasonSweep[7] = '{0, 1, 4, 12, 64, 127, 7};

  typedef struct {
    logic signed [StateW-1:0] fc_next;
    logic signed [StateW-1:0] fc_this;
    logic [DevW-1:0]          dev;
  } smoother_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [95:0]         m_axis_tdata;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [GainW-1:0]    cfg_data_i = '0;

  logic [GainW-1:0] alpha_q = GainReset;
  logic [GainW-1:0] beta_q = GainReset;
  logic [GainW-1:0] gamma_q = GainReset;
  logic [LenW-1:0]  season_len_q = '0;
  int level_s = 0;
  int trend_s = 0;
  int dev_single_s = 0;
  int last_fc_s = 0;
  int head_s = 0;
  int season_tbl[MaxSeason];
  int dev_tbl[MaxSeason];

  smoother_result_t pending_forecasts[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stuck_cycles = 0;

  holt_winters_smoother_step_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint gain_value(input logic [GainW-1:0] g);
    return (g > GainOne) ? longint'(GainOne) : longint'(g);
  endfunction

  // Weighted sum with the gain in Q1.16, rounded to nearest with halves away from zero.
  function automatic longint mix_q16(input longint g, input longint a, input longint b);
    longint v;
    v = g * a + (QOne - g) * b;
    if (v >= 0) begin
      return (v + QHalf) / QOne;
    end
    return -((-v + QHalf) / QOne);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > S32Max) begin
      return S32Max;
    end else if (v < S32Min) begin
      return S32Min;
    end
    return v;
  endfunction

  function automatic void clear_model();
    level_s = 0;
    trend_s = 0;
    dev_single_s = 0;
    last_fc_s = 0;
    head_s = 0;
    foreach (season_tbl[k]) begin
      season_tbl[k] = 0;
      dev_tbl[k] = 0;
    end
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
    case (idx)
      CfgLevelGain: alpha_q = val;
      CfgTrendGain: beta_q = val;
      CfgSeasonGain: gamma_q = val;
      CfgSeasonLength: season_len_q = val[LenW-1:0];
      default: return;
    endcase
    clear_model();
  endfunction

  function automatic smoother_result_t step_smoother(input logic signed [15:0] samp);
    longint x, ga, gb, gg, lvl_old, fc_old, s_old, lvl_new, trend_new;
    longint err, dev_old, dev_new, fc;
    int plen, h;
    bit seasonal;
    smoother_result_t r;
    x = longint'(samp) * 256;
    ga = gain_value(alpha_q);
    gb = gain_value(beta_q);
    gg = gain_value(gamma_q);
    plen = (season_len_q > MaxSeason) ? MaxSeason : int'(season_len_q);
    seasonal = plen > 0;
    h = (seasonal && head_s < plen) ? head_s : 0;
    lvl_old = level_s;
    fc_old = last_fc_s;
    if (seasonal) begin
      s_old = season_tbl[h];
      lvl_new = clamp32(mix_q16(ga, x - s_old, lvl_old + trend_s));
      season_tbl[h] = int'(clamp32(mix_q16(gg, x - lvl_new, s_old)));
    end else begin
      lvl_new = clamp32(mix_q16(ga, x, lvl_old + trend_s));
    end
    trend_new = clamp32(mix_q16(gb, lvl_new - lvl_old, trend_s));
    level_s = int'(lvl_new);
    trend_s = int'(trend_new);
    err = x - fc_old;
    if (err < 0) begin
      err = -err;
    end
    dev_old = seasonal ? dev_tbl[h] : dev_single_s;
    dev_new = mix_q16(gg, err, dev_old);
    if (dev_new < 0) begin
      dev_new = 0;
    end
    if (dev_new > S32Max) begin
      dev_new = S32Max;
    end
    dev_single_s = int'(dev_new);
    fc = lvl_new + trend_new;
    if (seasonal) begin
      dev_tbl[h] = int'(dev_new);
      h = (h + 1 >= plen) ? 0 : h + 1;
      head_s = h;
      fc += season_tbl[h];
    end else begin
      head_s = 0;
    end
    last_fc_s = int'(clamp32(fc));
    r.fc_next = last_fc_s;
    r.fc_this = fc_old[StateW-1:0];
    r.dev = seasonal ? dev_old[DevW-1:0] : dev_new[DevW-1:0];
    return r;
  endfunction

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return GainOne;
      2: return GainW'($urandom_range(65537, 131071));
      default: return GainW'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic check_result(input logic [95:0] d);
    smoother_result_t want;
    if (pending_forecasts.size() == 0) begin
      $error("unexpected result: nothing pending, got %h", d);
      mismatch_count++;
      return;
    end
    want = pending_forecasts.pop_front();
    if (d[31:0] !== want.fc_next) begin
      $error("forecast_next: expected %0d, got %0d", want.fc_next, $signed(d[31:0]));
      mismatch_count++;
    end
    if (d[63:32] !== want.fc_this) begin
      $error("forecast_this: expected %0d, got %0d", want.fc_this, $signed(d[63:32]));
      mismatch_count++;
    end
    if (d[94:64] !== want.dev) begin
      $error("deviation_out: expected %0d, got %0d", want.dev, d[94:64]);
      mismatch_count++;
    end
    if (d[95] !== 1'b0) begin
      $error("padding: expected 0, got %b", d[95]);
      mismatch_count++;
    end
  endtask

  // The receiver checks each result and decides its own stalls and long hold-offs.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
    end
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_sample(input logic [15:0] samp);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= samp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_forecasts.push_back(step_smoother(samp));
  endtask

  task automatic settle_outputs();
    s_axis_tvalid <= 1'b0;
    while (pending_forecasts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [GainW-1:0] alpha, input logic [GainW-1:0] beta,
                            input logic [GainW-1:0] gamma, input logic [GainW-1:0] len);
    write_reg(CfgLevelGain, alpha);
    write_reg(CfgTrendGain, beta);
    write_reg(CfgSeasonGain, gamma);
    write_reg(CfgSeasonLength, len);
  endtask

  // Reset settings: non-seasonal, all gains at one half, so halves get rounded.
  task automatic test_default_settings();
    send_sample(16'h0000);
    send_sample(16'h7fff);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hffff);
    send_sample(16'h5555);
    send_sample(16'haaaa);
    send_sample(16'h0000);
  endtask

  // Gains at zero, one and above one, and season lengths of one and beyond the ring.
  task automatic test_seasonal_extremes();
    settle_outputs();
    set_config(GainOne, '0, 17'd131071, 17'd3);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h1234);
    settle_outputs();
    set_config('0, GainOne, '0, 17'd100);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'hffff);
    send_sample(16'h0001);
    send_sample(16'h8000);
    settle_outputs();
    set_config(17'd1, 17'd131071, 17'd65535, 17'd1);
    send_sample(16'h7fff);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h4000);
  endtask

  // Writes to indexes beyond the last register must leave all state in place.
  task automatic test_unused_index();
    settle_outputs();
    set_config(17'd40000, 17'd20000, 17'd30000, 17'd6);
    repeat (5) send_sample(16'($urandom));
    settle_outputs();
    for (int i = int'(CfgUnusedLo); i <= int'(CfgUnusedHi); i++) begin
      write_reg(CfgIdxW'(i), GainW'($urandom));
    end
    repeat (6) send_sample(16'($urandom));
  endtask

  task automatic test_random_traffic();
    int pattern[MaxSeason];
    int period, offset, amp, slope, v;
    logic [LenW-1:0] len;
    for (int s = 0; s < 10; s++) begin
      settle_outputs();
      len = (s < 7) ? LenW'(SeasonSweep[s]) : LenW'($urandom_range(0, 127));
      set_config(pick_gain(), pick_gain(), pick_gain(), GainW'(len));
      for (int p = 0; p < 4; p++) begin
        send_idle_pct = SendIdle[p];
        recv_stall_pct <= RecvStall[p];
        if (len != 0 && $urandom_range(3) != 0) begin
          period = (len > MaxSeason) ? MaxSeason : int'(len);
        end else begin
          period = $urandom_range(1, MaxSeason);
        end
        offset = int'($urandom_range(0, 40000)) - 20000;
        amp = 1 << $urandom_range(0, 14);
        slope = int'($urandom_range(0, 64)) - 32;
        foreach (pattern[k]) begin
          pattern[k] = int'($urandom_range(0, 2 * amp)) - amp;
        end
        for (int n = 0; n < 33; n++) begin
          case ($urandom_range(9))
            0: v = $urandom_range(1) ? 32767 : -32768;
            1, 2: v = int'($signed(16'($urandom)));
            default: v = offset + pattern[n % period] + n * slope +
                         int'($urandom_range(0, 16)) - 8;
          endcase
          if (v > 32767) begin
            v = 32767;
          end else if (v < -32768) begin
            v = -32768;
          end
          send_sample(16'(v));
        end
      end
    end
  endtask

  // The receiver holds off while samples keep coming, so the unit must stall its input.
  task automatic test_output_backpressure();
    settle_outputs();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    set_config(pick_gain(), pick_gain(), pick_gain(), 17'd5);
    hold_len <= HoldCycles;
    hold_seq <= hold_seq + 1;
    repeat (12) send_sample(16'($urandom));
    settle_outputs();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_settings();
    test_seasonal_extremes();
    test_unused_index();
    test_random_traffic();
    test_output_backpressure();
    settle_outputs();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
